// ===== hdl/hmss_pkg.sv =====
// Shared constants, payload types and state encoding for the harmonic mean sound speed core.
`default_nettype none

package hmss_pkg;

    // Profile store size
    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Field widths
    localparam int KIND_W   = 2;
    localparam int DEPTH_W  = 21;
    localparam int SPEED_W  = 21;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;

    // Shared arithmetic units
    localparam int DIV_NUM_W    = 64;
    localparam int DIV_DEN_W    = 33;
    localparam int DIV_CNT_W    = $clog2(DIV_NUM_W + 1);
    localparam int MUL_A_W      = 38;
    localparam int MUL_B_W      = 33;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int SERIES_TERMS = 16;
    localparam int SER_W        = $clog2(SERIES_TERMS + 1);

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_INC = 3'd4;

    // Fixed point constants
    localparam logic [31:0]        LN2_Q32   = 32'd2977044472;
    localparam logic [33:0]        ONE_Q32   = 34'h1_0000_0000;
    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [DEPTH_W-1:0] depth;
        logic [SPEED_W-1:0] speed;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SPEED_W-1:0]  mean_speed;
    } t_out_item;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_req;

    // One profile node as held in the store
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [SPEED_W-1:0] speed;
        logic [TIME_W-1:0]  travel_time;
        logic [SPEED_W-1:0] harm;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WALK_RD,
        S_WALK_CHK,
        S_INTERP_MUL,
        S_INTERP_DIV,
        S_LT_START,
        S_EQ_DIV,
        S_REDUCE,
        S_X_DIV,
        S_X2_MUL,
        S_SER_INIT,
        S_SER_DIV,
        S_SER_MUL,
        S_SER_NEXT,
        S_K0_DIV,
        S_K0_MUL,
        S_K0_FIN,
        S_MAG_MUL,
        S_V_MUL,
        S_V_FIN,
        S_D_MUL,
        S_D_DIV,
        S_ACC,
        S_MEAN_DIV,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/hmss_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all divisions of the core.
`default_nettype none

module hmss_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hmss_pkg::t_div_req                i_req,
    output logic                              o_done,
    output logic [hmss_pkg::DIV_NUM_W-1:0]    o_quot
);
    import hmss_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W+1:0] diff;
    logic                 ge;

    // Shift in the next dividend bit and try a subtract
    assign rem_sh = {r_rem, r_num[DIV_NUM_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_den};
    assign ge     = ~diff[DIV_DEN_W+1];

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            r_num <= {r_num[DIV_NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

`default_nettype wire

// ===== hdl/harmonic_mean_sound_speed_core.sv =====
// Top level: profile store, sequencer and shared multiplier of the harmonic mean sound speed core.
// Each item produces exactly one result. A clear, a rejected append, an out of range query,
// the first appended point and a query that hits the top node pass from idle straight to
// the result state. A query walks the stored nodes, one memory read per node passed. Any
// layer computation then runs a sequence of divisions on one shared divider that yields
// one quotient bit per cycle: interpolation, ratio, one per nonzero series term (one to
// seven), layer time and mean. A constant speed layer needs only the layer time and mean
// divisions, plus interpolation and the walk for a query.
// The input is stalled while an item is in work; a finished result waits in the output
// register while the next item is taken.
`default_nettype none

module harmonic_mean_sound_speed_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  hmss_pkg::t_in_item     i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output hmss_pkg::t_out_item    o_out_item
);
    import hmss_pkg::*;

    function automatic logic [24:0] times10(input logic [DEPTH_W-1:0] v);
        return ({4'b0, v} << 3) + ({4'b0, v} << 1);
    endfunction

    function automatic logic [TIME_W-1:0] sat_time(input logic [DIV_NUM_W-1:0] v);
        return (v[DIV_NUM_W-1:TIME_W] != '0) ? TIME_MAX : v[TIME_W-1:0];
    endfunction

    // Control registers
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             r_dwait, n_dwait;

    // Payload registers
    t_out_item          r_out, n_out;
    t_out_item          r_res, n_res;
    logic               r_is_append, n_is_append;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [SPEED_W-1:0] r_speed, n_speed;
    logic [DEPTH_W-1:0] r_top_depth, n_top_depth;
    logic [SPEED_W-1:0] r_top_speed, n_top_speed;
    logic [DEPTH_W-1:0] r_last_depth, n_last_depth;
    logic [SPEED_W-1:0] r_last_speed, n_last_speed;
    logic [TIME_W-1:0]  r_last_time, n_last_time;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [DEPTH_W-1:0] r_pd, n_pd;
    logic [SPEED_W-1:0] r_ps, n_ps;
    logic [TIME_W-1:0]  r_pt, n_pt;
    logic [DEPTH_W-1:0] r_span, n_span;
    logic [DEPTH_W-1:0] r_off, n_off;
    logic [SPEED_W-1:0] r_cn, n_cn;
    logic               r_up, n_up;
    logic [SPEED_W-1:0] r_ca, n_ca;
    logic [SPEED_W-1:0] r_cb, n_cb;
    logic [24:0]        r_dzmm, n_dzmm;
    logic [TIME_W-1:0]  r_base, n_base;
    logic [22:0]        r_a, n_a;
    logic [22:0]        r_b, n_b;
    logic signed [5:0]  r_k, n_k;
    logic               r_neg, n_neg;
    logic [31:0]        r_xq, n_xq;
    logic [31:0]        r_x2, n_x2;
    logic [32:0]        r_term, n_term;
    logic [33:0]        r_s, n_s;
    logic [SER_W-1:0]   r_i, n_i;
    logic [31:0]        r_q, n_q;
    logic [MUL_A_W-1:0] r_mag, n_mag;
    logic [TIME_W-1:0]  r_lt, n_lt;
    logic [TIME_W-1:0]  r_t, n_t;
    logic [PROD_W-1:0]  r_prod;

    // Profile store
    t_entry r_mem [MAX_POINTS];
    t_entry r_rd;
    logic   mem_we;
    t_entry mem_wd;

    // Shared units
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    t_div_req             div_req;
    logic                 div_sel;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_q;

    // Datapath helpers
    logic [SPEED_W-1:0] in_sp;
    logic [25:0]        two_a, two_b, three_a, three_b;
    logic [22:0]        x_num;
    logic [23:0]        x_den;
    logic [SPEED_W-1:0] cab_diff;
    logic [21:0]        cab_sum;
    logic [28:0]        d_den;
    logic [33:0]        s_m1_full;
    logic [5:0]         k_abs;
    logic               ser_go;
    logic [SPEED_W-1:0] node_diff;
    logic [64:0]        k0_rnd;
    logic [33:0]        k0_sum;
    logic [32:0]        acc;
    logic [TIME_W-1:0]  t_nz;
    logic [DEPTH_W-1:0] dz_top;
    logic [SPEED_W-1:0] mean_sat;
    logic               out_free;

    assign in_sp     = (i_in_item.speed == '0) ? SPEED_W'(1) : i_in_item.speed;
    assign two_a     = {2'b0, r_a, 1'b0};
    assign two_b     = {2'b0, r_b, 1'b0};
    assign three_a   = {3'b0, r_a} + {2'b0, r_a, 1'b0};
    assign three_b   = {3'b0, r_b} + {2'b0, r_b, 1'b0};
    assign x_num     = r_neg ? (r_a - r_b) : (r_b - r_a);
    assign x_den     = {1'b0, r_a} + {1'b0, r_b};
    assign cab_diff  = (r_cb > r_ca) ? (r_cb - r_ca) : (r_ca - r_cb);
    assign cab_sum   = {1'b0, r_ca} + {1'b0, r_cb};
    assign d_den     = {cab_diff, 8'b0};
    assign s_m1_full = r_s - ONE_Q32;
    assign k_abs     = r_k[5] ? (~r_k + 6'd1) : r_k;
    assign ser_go    = (r_term != '0) && (r_i != SER_W'(SERIES_TERMS));
    assign node_diff = r_up ? (r_cn - r_ps) : (r_ps - r_cn);
    assign k0_rnd    = {1'b0, r_prod[63:0]} + 65'h0_8000_0000;
    assign k0_sum    = {2'b0, r_q} + {1'b0, k0_rnd[64:32]};
    assign acc       = {1'b0, r_base} + {1'b0, r_lt};
    assign t_nz      = (r_t == '0) ? TIME_W'(1) : r_t;
    assign dz_top    = r_depth - r_top_depth;
    assign mean_sat  = (div_q[DIV_NUM_W-1:SPEED_W] != '0) ? SPEED_MAX : div_q[SPEED_W-1:0];
    assign out_free  = !r_out_valid || !i_out_stall;

    // Store: one write port at the fill index, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_cnt[ADDR_W-1:0]] <= mem_wd;
        end
        r_rd <= r_mem[r_addr];
    end

    // Shared multiplier operand select, product registered
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_INTERP_MUL: begin
                mul_a = MUL_A_W'(node_diff);
                mul_b = MUL_B_W'(r_off);
            end
            S_X2_MUL: begin
                mul_a = MUL_A_W'(r_xq);
                mul_b = MUL_B_W'(r_xq);
            end
            S_SER_MUL: begin
                mul_a = MUL_A_W'(r_term);
                mul_b = MUL_B_W'(r_x2);
            end
            S_K0_MUL: begin
                mul_a = MUL_A_W'(r_q);
                mul_b = MUL_B_W'(s_m1_full[31:0]);
            end
            S_MAG_MUL: begin
                mul_a = MUL_A_W'(k_abs);
                mul_b = MUL_B_W'(LN2_Q32);
            end
            S_V_MUL: begin
                mul_a = MUL_A_W'(r_xq);
                mul_b = r_s[MUL_B_W-1:0];
            end
            S_D_MUL: begin
                mul_a = r_mag;
                mul_b = MUL_B_W'(r_dzmm);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Divider operand select
    always_comb begin
        div_sel = 1'b0;
        div_num = '0;
        div_den = '0;
        case (r_state)
            S_INTERP_DIV: begin
                div_sel = 1'b1;
                div_num = DIV_NUM_W'(r_prod[41:0]) + DIV_NUM_W'(r_span >> 1);
                div_den = DIV_DEN_W'(r_span);
            end
            S_EQ_DIV: begin
                div_sel = 1'b1;
                div_num = {15'b0, r_dzmm, 24'b0} + DIV_NUM_W'(r_ca >> 1);
                div_den = DIV_DEN_W'(r_ca);
            end
            S_X_DIV: begin
                div_sel = 1'b1;
                div_num = {9'b0, x_num, 32'b0};
                div_den = DIV_DEN_W'(x_den);
            end
            S_SER_DIV: begin
                div_sel = ser_go;
                div_num = DIV_NUM_W'(r_term);
                div_den = DIV_DEN_W'({r_i, 1'b1});
            end
            S_K0_DIV: begin
                div_sel = 1'b1;
                div_num = {14'b0, r_dzmm, 25'b0} + DIV_NUM_W'(cab_sum >> 1);
                div_den = DIV_DEN_W'(cab_sum);
            end
            S_D_DIV: begin
                div_sel = 1'b1;
                div_num = r_prod[63:0] + DIV_NUM_W'(d_den >> 1);
                div_den = DIV_DEN_W'(d_den);
            end
            S_MEAN_DIV: begin
                div_sel = 1'b1;
                div_num = {15'b0, times10(dz_top), 24'b0} + DIV_NUM_W'(t_nz >> 1);
                div_den = DIV_DEN_W'(t_nz);
            end
            default: ;
        endcase
    end

    assign div_req.start    = div_sel && !r_dwait;
    assign div_req.dividend = div_num;
    assign div_req.divisor  = div_den;

    hmss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && i_out_stall;
        n_dwait      = r_dwait;
        n_out        = r_out;
        n_res        = r_res;
        n_is_append  = r_is_append;
        n_depth      = r_depth;
        n_speed      = r_speed;
        n_top_depth  = r_top_depth;
        n_top_speed  = r_top_speed;
        n_last_depth = r_last_depth;
        n_last_speed = r_last_speed;
        n_last_time  = r_last_time;
        n_addr       = r_addr;
        n_pd         = r_pd;
        n_ps         = r_ps;
        n_pt         = r_pt;
        n_span       = r_span;
        n_off        = r_off;
        n_cn         = r_cn;
        n_up         = r_up;
        n_ca         = r_ca;
        n_cb         = r_cb;
        n_dzmm       = r_dzmm;
        n_base       = r_base;
        n_a          = r_a;
        n_b          = r_b;
        n_k          = r_k;
        n_neg        = r_neg;
        n_xq         = r_xq;
        n_x2         = r_x2;
        n_term       = r_term;
        n_s          = r_s;
        n_i          = r_i;
        n_q          = r_q;
        n_mag        = r_mag;
        n_lt         = r_lt;
        n_t          = r_t;
        mem_we       = 1'b0;
        mem_wd       = '0;

        if (div_req.start) begin
            n_dwait = 1'b1;
        end

        case (r_state)
            // Take an item and settle the cases that need no arithmetic
            S_IDLE: begin
                if (i_in_valid) begin
                    n_depth = i_in_item.depth;
                    n_speed = in_sp;
                    n_res   = '0;
                    n_state = S_FIN;
                    case (i_in_item.kind)
                        KIND_APPEND: begin
                            n_is_append = 1'b1;
                            if (r_cnt >= CNT_W'(MAX_POINTS)) begin
                                n_res.status = ST_FULL;
                            end else if (r_cnt != '0 && i_in_item.depth <= r_last_depth) begin
                                n_res.status = ST_NOT_INC;
                            end else if (r_cnt == '0) begin
                                mem_we       = 1'b1;
                                mem_wd       = '{depth: i_in_item.depth, speed: in_sp,
                                                 travel_time: '0, harm: in_sp};
                                n_top_depth  = i_in_item.depth;
                                n_top_speed  = in_sp;
                                n_last_depth = i_in_item.depth;
                                n_last_speed = in_sp;
                                n_last_time  = '0;
                                n_cnt        = r_cnt + CNT_W'(1);
                                n_res.mean_speed = in_sp;
                            end else begin
                                n_ca    = r_last_speed;
                                n_cb    = in_sp;
                                n_dzmm  = times10(i_in_item.depth - r_last_depth);
                                n_base  = r_last_time;
                                n_state = S_LT_START;
                            end
                        end
                        KIND_QUERY: begin
                            n_is_append = 1'b0;
                            if (r_cnt == '0 || i_in_item.depth < r_top_depth ||
                                i_in_item.depth > r_last_depth) begin
                                n_res.status = ST_RANGE;
                            end else if (i_in_item.depth == r_top_depth) begin
                                n_res.mean_speed = r_top_speed;
                            end else begin
                                n_addr  = ADDR_W'(1);
                                n_pd    = r_top_depth;
                                n_ps    = r_top_speed;
                                n_pt    = '0;
                                n_state = S_WALK_RD;
                            end
                        end
                        KIND_CLEAR: begin
                            n_cnt = '0;
                        end
                        default: ;
                    endcase
                end
            end

            // Node walk: one read per node
            S_WALK_RD: begin
                n_state = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                if (r_depth == r_rd.depth) begin
                    n_res.mean_speed = r_rd.harm;
                    n_state          = S_FIN;
                end else if (r_depth < r_rd.depth) begin
                    n_span  = r_rd.depth - r_pd;
                    n_off   = r_depth - r_pd;
                    n_cn    = r_rd.speed;
                    n_up    = r_rd.speed >= r_ps;
                    n_state = S_INTERP_MUL;
                end else begin
                    n_pd    = r_rd.depth;
                    n_ps    = r_rd.speed;
                    n_pt    = r_rd.travel_time;
                    n_addr  = r_addr + ADDR_W'(1);
                    n_state = S_WALK_RD;
                end
            end

            // Linear speed at the query depth
            S_INTERP_MUL: begin
                n_state = S_INTERP_DIV;
            end
            S_INTERP_DIV: begin
                if (div_done) begin
                    n_dwait = 1'b0;
                    n_ca    = r_ps;
                    n_cb    = r_up ? (r_ps + div_q[SPEED_W-1:0]) : (r_ps - div_q[SPEED_W-1:0]);
                    n_dzmm  = times10(r_off);
                    n_base  = r_pt;
                    n_state = S_LT_START;
                end
            end

            // Layer travel time
            S_LT_START: begin
                if (r_ca == r_cb) begin
                    n_state = S_EQ_DIV;
                end else begin
                    n_a     = 23'(r_ca);
                    n_b     = 23'(r_cb);
                    n_k     = '0;
                    n_state = S_REDUCE;
                end
            end
            S_EQ_DIV: begin
                if (div_done) begin
                    n_dwait = 1'b0;
                    n_lt    = sat_time(div_q);
                    n_state = S_ACC;
                end
            end
            // Bring the ratio into [2/3, 3/2] by doubling, one step a cycle
            S_REDUCE: begin
                if (two_b > three_a) begin
                    n_a = {r_a[21:0], 1'b0};
                    n_k = r_k + 6'sd1;
                end else if (two_a > three_b) begin
                    n_b = {r_b[21:0], 1'b0};
                    n_k = r_k - 6'sd1;
                end else begin
                    n_neg   = r_b < r_a;
                    n_state = S_X_DIV;
                end
            end
            S_X_DIV: begin
                if (div_done) begin
                    n_dwait = 1'b0;
                    n_xq    = div_q[31:0];
                    n_state = S_X2_MUL;
                end
            end
            S_X2_MUL: begin
                n_state = S_SER_INIT;
            end
            S_SER_INIT: begin
                n_x2    = r_prod[63:32];
                n_term  = 33'h1_0000_0000;
                n_s     = '0;
                n_i     = '0;
                n_state = S_SER_DIV;
            end
            // Series terms; stops early once a term has vanished
            S_SER_DIV: begin
                if (!ser_go) begin
                    n_state = (r_k == '0) ? S_K0_DIV : S_MAG_MUL;
                end else if (div_done) begin
                    n_dwait = 1'b0;
                    n_s     = r_s + div_q[33:0];
                    n_state = S_SER_MUL;
                end
            end
            S_SER_MUL: begin
                n_state = S_SER_NEXT;
            end
            S_SER_NEXT: begin
                n_term  = r_prod[64:32];
                n_i     = r_i + SER_W'(1);
                n_state = S_SER_DIV;
            end
            // No doubling: time from the mean of the end speeds and the series
            S_K0_DIV: begin
                if (div_done) begin
                    n_dwait = 1'b0;
                    if (div_q[DIV_NUM_W-1:32] != '0) begin
                        n_lt    = TIME_MAX;
                        n_state = S_ACC;
                    end else begin
                        n_q     = div_q[31:0];
                        n_state = S_K0_MUL;
                    end
                end
            end
            S_K0_MUL: begin
                n_state = S_K0_FIN;
            end
            S_K0_FIN: begin
                n_lt    = (k0_sum[33:32] != '0) ? TIME_MAX : k0_sum[31:0];
                n_state = S_ACC;
            end
            // Log by k*ln2 plus the series part, then divide by the gradient
            S_MAG_MUL: begin
                n_state = S_V_MUL;
            end
            S_V_MUL: begin
                n_mag   = r_prod[MUL_A_W-1:0];
                n_state = S_V_FIN;
            end
            S_V_FIN: begin
                if (!r_k[5] != r_neg) begin
                    n_mag = r_mag + MUL_A_W'(r_prod[63:31]);
                end else begin
                    n_mag = r_mag - MUL_A_W'(r_prod[63:31]);
                end
                n_state = S_D_MUL;
            end
            S_D_MUL: begin
                n_state = S_D_DIV;
            end
            S_D_DIV: begin
                if (div_done) begin
                    n_dwait = 1'b0;
                    n_lt    = sat_time(div_q);
                    n_state = S_ACC;
                end
            end

            // Cumulative time and harmonic mean
            S_ACC: begin
                n_t     = acc[TIME_W] ? TIME_MAX : acc[TIME_W-1:0];
                n_state = S_MEAN_DIV;
            end
            S_MEAN_DIV: begin
                if (div_done) begin
                    n_dwait          = 1'b0;
                    n_res.mean_speed = mean_sat;
                    if (r_is_append) begin
                        mem_we       = 1'b1;
                        mem_wd       = '{depth: r_depth, speed: r_speed,
                                         travel_time: r_t, harm: mean_sat};
                        n_last_depth = r_depth;
                        n_last_speed = r_speed;
                        n_last_time  = r_t;
                        n_cnt        = r_cnt + CNT_W'(1);
                    end
                    n_state = S_FIN;
                end
            end

            // Hand the result to the output register
            S_FIN: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_dwait     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_dwait     <= n_dwait;
        end
    end

    // Payload state
    always_ff @(posedge i_clk) begin
        r_out        <= n_out;
        r_res        <= n_res;
        r_is_append  <= n_is_append;
        r_depth      <= n_depth;
        r_speed      <= n_speed;
        r_top_depth  <= n_top_depth;
        r_top_speed  <= n_top_speed;
        r_last_depth <= n_last_depth;
        r_last_speed <= n_last_speed;
        r_last_time  <= n_last_time;
        r_addr       <= n_addr;
        r_pd         <= n_pd;
        r_ps         <= n_ps;
        r_pt         <= n_pt;
        r_span       <= n_span;
        r_off        <= n_off;
        r_cn         <= n_cn;
        r_up         <= n_up;
        r_ca         <= n_ca;
        r_cb         <= n_cb;
        r_dzmm       <= n_dzmm;
        r_base       <= n_base;
        r_a          <= n_a;
        r_b          <= n_b;
        r_k          <= n_k;
        r_neg        <= n_neg;
        r_xq         <= n_xq;
        r_x2         <= n_x2;
        r_term       <= n_term;
        r_s          <= n_s;
        r_i          <= n_i;
        r_q          <= n_q;
        r_mag        <= n_mag;
        r_lt         <= n_lt;
        r_t          <= n_t;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Checks
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store size");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> r_cnt < CNT_W'(MAX_POINTS))
        else $error("store written while full");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK_CHK |-> CNT_W'(r_addr) < r_cnt)
        else $error("walk read past the last node");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |-> o_out_item.mean_speed == '0)
        else $error("error result carries a speed");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_dwait && div_sel)
        else $error("divider finished with no division pending");

endmodule

`default_nettype wire

// ===== test/tb_harmonic_mean_sound_speed_core.sv =====
// Testbench for the harmonic mean sound speed core: random and directed profile items.
`timescale 1ns / 1ps

module tb_harmonic_mean_sound_speed_core;
    import hmss_pkg::*;

    localparam longint TMAX = 64'hFFFF_FFFF;
    localparam longint SMAX = 64'h1F_FFFF;
    localparam longint LIMIT_CYCLES = 8_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in_item = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_item o_out_item;

    harmonic_mean_sound_speed_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item)
    );

    always #1 i_clk = ~i_clk;

    // Profile shadow
    int unsigned prof_count;
    longint prof_depth [MAX_POINTS];
    longint prof_speed [MAX_POINTS];
    longint prof_time [MAX_POINTS];
    longint prof_harm [MAX_POINTS];

    t_in_item pending_items [$];
    t_out_item expected_results [$];
    int errors = 0;
    int n_results = 0;
    longint cycle = 0;
    bit calm = 0;      // no idling stretch
    int hold_off = 0;  // long receiver stall

    function automatic longint sat_t(longint t);
        return (t > TMAX) ? TMAX : t;
    endfunction

    // Travel time through a layer of linear speed
    function automatic longint layer_travel(longint dz_cm, longint ca, longint cb);
        longint unsigned dz_mm, a, b, num, den, xq, x2, term, s, mag, v, d, sum, q, q_corr;
        int k;
        bit neg;
        dz_mm = dz_cm * 10;
        a = ca; b = cb; k = 0;
        if (ca == cb) return sat_t(((dz_mm << 24) + ca / 2) / ca);
        for (int i = 0; i < 22; i++) if (2 * b > 3 * a) begin a <<= 1; k++; end
        for (int i = 0; i < 22; i++) if (2 * a > 3 * b) begin b <<= 1; k--; end
        neg = b < a;
        num = neg ? a - b : b - a;
        den = a + b;
        for (int i = 0; i < 16; i++) if (den >= (64'd1 << 31)) begin den >>= 1; num >>= 1; end
        xq = (num << 32) / den;
        x2 = (xq * xq) >> 32;
        term = 64'd1 << 32;
        s = 0;
        for (int i = 0; i < SERIES_TERMS; i++) begin
            s += term / (2 * i + 1);
            term = (term * x2) >> 32;
        end
        if (k == 0) begin
            sum = ca + cb;
            q = ((dz_mm << 25) + sum / 2) / sum;
            if (q > TMAX) return TMAX;
            q_corr = (q * (s - (64'd1 << 32)) + (64'd1 << 31)) >> 32;
            return sat_t(q + q_corr);
        end
        mag = longint'((k > 0) ? k : -k) * LN2_Q32;
        v = (xq * s) >> 31;
        if ((k > 0) != neg) mag += v;
        else mag -= v;
        d = ((cb > ca) ? cb - ca : ca - cb) << 8;
        return sat_t((dz_mm * mag + d / 2) / d);
    endfunction

    function automatic longint mean_over(longint dz_cm, longint t);
        longint unsigned m;
        if (t == 0) t = 1;
        m = (((dz_cm * 10) << 24) + t / 2) / t;
        return (m > SMAX) ? SMAX : m;
    endfunction

    // Predict one result and update the shadow profile
    function automatic t_out_item predict_profile(t_in_item it);
        t_out_item r;
        longint dep, spd, t, c0, c1, span, off, c;
        bit found;
        r = '0;
        dep = it.depth;
        spd = it.speed;
        case (it.kind)
            KIND_APPEND: begin
                if (spd == 0) spd = 1;
                if (prof_count >= MAX_POINTS) r.status = ST_FULL;
                else if (prof_count > 0 && dep <= prof_depth[prof_count-1]) r.status = ST_NOT_INC;
                else begin
                    prof_depth[prof_count] = dep;
                    prof_speed[prof_count] = spd;
                    if (prof_count == 0) begin
                        prof_time[0] = 0;
                        prof_harm[0] = spd;
                    end else begin
                        t = sat_t(prof_time[prof_count-1] + layer_travel(
                            dep - prof_depth[prof_count-1], prof_speed[prof_count-1], spd));
                        prof_time[prof_count] = t;
                        prof_harm[prof_count] = mean_over(dep - prof_depth[0], t);
                    end
                    r.mean_speed = SPEED_W'(prof_harm[prof_count]);
                    prof_count++;
                end
            end
            KIND_QUERY: begin
                if (prof_count == 0 || dep < prof_depth[0] || dep > prof_depth[prof_count-1])
                    r.status = ST_RANGE;
                else if (dep == prof_depth[0]) r.mean_speed = SPEED_W'(prof_speed[0]);
                else begin
                    found = 0;
                    for (int i = 0; i + 1 < prof_count && !found; i++) begin
                        if (dep == prof_depth[i+1]) begin
                            r.mean_speed = SPEED_W'(prof_harm[i+1]); found = 1;
                        end else if (dep > prof_depth[i] && dep < prof_depth[i+1]) begin
                            c0 = prof_speed[i]; c1 = prof_speed[i+1];
                            span = prof_depth[i+1] - prof_depth[i];
                            off = dep - prof_depth[i];
                            if (c1 >= c0) c = c0 + ((c1 - c0) * off + span / 2) / span;
                            else c = c0 - ((c0 - c1) * off + span / 2) / span;
                            t = sat_t(prof_time[i] + layer_travel(off, c0, c));
                            r.mean_speed = SPEED_W'(mean_over(dep - prof_depth[0], t));
                            found = 1;
                        end
                    end
                end
            end
            KIND_CLEAR: prof_count = 0;
            default: ;
        endcase
        return r;
    endfunction

    // Driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(predict_profile(i_in_item));
                void'(pending_items.pop_front());
            end
            if ((!i_in_valid || !o_in_stall)) begin
                if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
                    i_in_valid <= 1'b1;
                    i_in_item <= pending_items[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stall
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result status=%0d mean=%0d", $time,
                             o_out_item.status, o_out_item.mean_speed);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.status !== o_out_item.status)
                        begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_r.status, o_out_item.status);
                        errors++;
                    end
                    if (exp_r.mean_speed !== o_out_item.mean_speed) begin
                        $display("%0t: mean_speed expected %0d actual %0d", $time,
                                 exp_r.mean_speed, o_out_item.mean_speed);
                        errors++;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < 34);
            end
        end
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT_CYCLES) begin
            $display("** harmonic_mean_sound_speed_core: FAILED **");
            $finish;
        end
    end

    function automatic t_in_item mk(logic [KIND_W-1:0] k, int unsigned d, int unsigned s);
        t_in_item it;
        it.kind = k; it.depth = DEPTH_W'(d); it.speed = SPEED_W'(s);
        return it;
    endfunction

    // Random append speed: mostly realistic, sometimes extreme
    function automatic int unsigned rnd_speed();
        case ($urandom_range(9))
            0: return $urandom_range(2097151);
            1: return $urandom_range(3);
            default: return $urandom_range(1450000, 1550000);
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    // A well-formed profile with queries, plus a bit of noise
    task automatic add_profile_burst(int unsigned npts, int unsigned nq);
        int unsigned d, top, bot;
        d = $urandom_range(20000);
        top = d;
        pending_items.push_back(mk(KIND_CLEAR, $urandom, $urandom));
        for (int i = 0; i < npts; i++) begin
            if ($urandom_range(15) == 0) pending_items.push_back(mk(KIND_APPEND, d, rnd_speed()));
            pending_items.push_back(mk(KIND_APPEND, d, rnd_speed()));
            bot = d;
            d += $urandom_range(1, 40000);
            if (d > 2097151) d = 2097151;
        end
        for (int i = 0; i < nq; i++) begin
            case ($urandom_range(7))
                0: pending_items.push_back(mk(KIND_QUERY, $urandom_range(2097151), 0));
                1: pending_items.push_back(mk(KIND_QUERY, top, $urandom));
                2: pending_items.push_back(mk(KIND_QUERY, bot, $urandom));
                3: pending_items.push_back(mk(2'd3, $urandom, $urandom));
                default: pending_items.push_back(mk(KIND_QUERY,
                                                   $urandom_range(bot, top), $urandom));
            endcase
        end
    endtask

    initial begin
        int total;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty query, extremes, kind three, zero speed, not increasing
        pending_items.push_back(mk(KIND_QUERY, 100, 0));
        pending_items.push_back(mk(2'd3, 2097151, 2097151));
        pending_items.push_back(mk(KIND_APPEND, 0, 0));
        pending_items.push_back(mk(KIND_APPEND, 1000, 2097151));
        pending_items.push_back(mk(KIND_APPEND, 1000, 1500000));
        pending_items.push_back(mk(KIND_APPEND, 500, 1500000));
        pending_items.push_back(mk(KIND_APPEND, 2097151, 2097151));
        pending_items.push_back(mk(KIND_QUERY, 0, 0));
        pending_items.push_back(mk(KIND_QUERY, 1000, 0));
        pending_items.push_back(mk(KIND_QUERY, 500, 0));
        pending_items.push_back(mk(KIND_QUERY, 2097151, 0));
        pending_items.push_back(mk(KIND_QUERY, 1048576, 0));
        pending_items.push_back(mk(KIND_CLEAR, 0, 0));
        pending_items.push_back(mk(KIND_APPEND, 100, 1500000));
        pending_items.push_back(mk(KIND_APPEND, 200, 1500000));
        pending_items.push_back(mk(KIND_QUERY, 150, 0));
        pending_items.push_back(mk(KIND_QUERY, 50, 0));
        pending_items.push_back(mk(KIND_QUERY, 300, 0));
        wait_drained();

        // Fill the profile to the limit, then overflow it
        pending_items.push_back(mk(KIND_CLEAR, 0, 0));
        for (int i = 0; i < MAX_POINTS + 2; i++)
            pending_items.push_back(mk(KIND_APPEND, i * 30000, rnd_speed()));
        pending_items.push_back(mk(KIND_QUERY, 63 * 30000 - 7, 0));
        wait_drained();

        // Long receiver hold-off while the sender keeps offering
        calm = 1;
        add_profile_burst(4, 8);
        hold_off = 3000;
        wait_drained();

        // Random profiles; first stretch without idling
        total = 0;
        while (total < 1350) begin
            calm = (total < 150);
            add_profile_burst($urandom_range(1, 8), $urandom_range(2, 10));
            total += pending_items.size();
            wait_drained();
        end
        calm = 0;
        repeat (2000) @(posedge i_clk);
        $display("Run covered %0d results over directed, full-profile and random profile items.",
                 n_results);
        if (errors == 0 && expected_results.size() == 0)
            $display("** harmonic_mean_sound_speed_core: PASSED **");
        else
            $display("** harmonic_mean_sound_speed_core: FAILED **");
        $finish;
    end
endmodule
